[rtl/biq_pkg.sv]
// biq_pkg: widths, stage counts, class codes and the pipeline item type of the root solver
`default_nettype none
package biq_pkg;

	// input and output formats
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = 26;

	// discriminant b^2 - 4ac and its positive radicand
	localparam int D_W       = 2 * COEF_W + 3;
	localparam int DR_W      = 2 * COEF_W + 1;

	// sqrt of the discriminant scaled by 2^(2*FRAC_BITS)
	localparam int SQD_N     = (DR_W + 2 * FRAC_BITS + 1) / 2;
	localparam int SQD_RAD_W = 2 * SQD_N;
	localparam int SQD_REM_W = SQD_N + 3;

	// numerators, denominators and the restoring divider
	localparam int NUM_W     = SQD_N + 2;
	localparam int MAG_W     = NUM_W - 1;
	localparam int DEN_W     = COEF_W + 1;
	localparam int DREM_W    = DEN_W + 1;

	// sqrt of the y root scaled by 2^FRAC_BITS
	localparam int RT_N      = (MAG_W + FRAC_BITS + 1) / 2;
	localparam int RT_RAD_W  = 2 * RT_N;
	localparam int RT_REM_W  = RT_N + 3;

	// recurrence steps per pipeline stage and the resulting stage counts
	localparam int STEPS     = 2;
	localparam int SQD_ST    = (SQD_N + STEPS - 1) / STEPS;
	localparam int DIV_ST    = (MAG_W + STEPS - 1) / STEPS;
	localparam int RT_ST     = (RT_N + STEPS - 1) / STEPS;
	localparam int NUM_IDX   = SQD_ST + 1;
	localparam int DIV_FIRST = NUM_IDX + 1;
	localparam int RT_FIRST  = DIV_FIRST + DIV_ST;
	localparam int N_CH      = RT_FIRST + RT_ST - 1;

	// solution classes
	typedef enum logic [2:0] {
		CLS_FOUR   = 3'd0,
		CLS_TWO    = 3'd1,
		CLS_DOUBLE = 3'd2,
		CLS_NONE   = 3'd3,
		CLS_INF    = 3'd4
	} cls_t;

	// one equation in flight
	typedef struct packed {
		cls_t                              cls;
		logic [2:0]                        cnt;
		logic                              sel1;
		logic                              lin;
		logic signed [COEF_W-1:0]          b;
		logic signed [COEF_W-1:0]          c;
		logic signed [DEN_W-1:0]           den;
		logic [SQD_RAD_W-1:0]              sq_rad;
		logic [SQD_REM_W-1:0]              sq_rem;
		logic [SQD_N-1:0]                  sq_root;
		logic [1:0][MAG_W-1:0]             dv_q;
		logic [1:0][DREM_W-1:0]            dv_rem;
		logic [1:0]                        dv_neg;
		logic [DEN_W-1:0]                  dv_den;
		logic [1:0][RT_RAD_W-1:0]          rt_rad;
		logic [1:0][RT_REM_W-1:0]          rt_rem;
		logic [1:0][RT_N-1:0]              rt_root;
	} item_t;

endpackage
`default_nettype wire

[rtl/biquadratic_root_solver.sv]
// throughput: one equation per cycle while out_stall stays low; the pipeline holds up to 51 equations in flight
// the latency is set by the digit recurrences (sqrt of the discriminant, the two dividers
// and the two final roots), two recurrence steps per pipeline stage
// reset clears the valid bits of every stage and of the output register; payload is not reset
`default_nettype none
module biquadratic_root_solver import biq_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [COEF_W-1:0] coef_quartic,
	input  wire logic signed [COEF_W-1:0] coef_square,
	input  wire logic signed [COEF_W-1:0] coef_const,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [2:0]                    solution_class,
	output logic [2:0]                    root_count,
	output logic signed [OUT_W-1:0]       root_one,
	output logic signed [OUT_W-1:0]       root_two,
	output logic signed [OUT_W-1:0]       root_three,
	output logic signed [OUT_W-1:0]       root_four
);

	logic adv;

	logic                       v_s1;
	logic signed [COEF_W-1:0]   a_s1, b_s1, c_s1;
	logic signed [2*COEF_W-1:0] bb_s1, ac_s1;

	item_t dec_d;
	item_t chn_s [0:N_CH];
	logic  chn_v_s [0:N_CH];
	item_t chn_d [1:N_CH];

	logic                 out_valid_q;
	cls_t                 cls_q;
	logic [2:0]           cnt_q;
	logic [OUT_W-1:0]     r1_q, r2_q, r3_q, r4_q;

	// whole pipeline moves unless the output beat is held
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= coef_quartic;
			b_s1  <= coef_square;
			c_s1  <= coef_const;
			bb_s1 <= coef_square * coef_square;
			ac_s1 <= coef_quartic * coef_const;
		end
	end

	// stage 2: discriminant, classification and divider denominator
	always_comb begin
		logic signed [D_W-1:0] d;
		logic ok1, ok2;
		dec_d = '0;
		d     = D_W'(bb_s1) - (D_W'(ac_s1) <<< 2);
		if (b_s1 <= 0) ok1 = (a_s1 > 0);
		else           ok1 = (ac_s1 == 0) || ((ac_s1 < 0) == (a_s1 > 0));
		if (b_s1 >= 0) ok2 = (a_s1 < 0);
		else           ok2 = (ac_s1 == 0) || ((ac_s1 > 0) == (a_s1 > 0));
		dec_d.cls  = CLS_NONE;
		dec_d.cnt  = 3'd0;
		dec_d.sel1 = 1'b0;
		dec_d.lin  = (a_s1 == 0);
		dec_d.b    = b_s1;
		dec_d.c    = c_s1;
		dec_d.den  = (a_s1 != 0) ? (DEN_W'(a_s1) <<< 1) : DEN_W'(b_s1);
		if (a_s1 != 0) begin
			if (d > 0) begin
				if (ok1 && ok2) begin
					dec_d.cls = CLS_FOUR;
					dec_d.cnt = 3'd4;
				end else if (ok1 || ok2) begin
					dec_d.cls  = CLS_TWO;
					dec_d.cnt  = 3'd2;
					dec_d.sel1 = !ok1;
				end
			end else if (d == 0) begin
				if (b_s1 == 0 || ((b_s1 > 0) != (a_s1 > 0))) begin
					dec_d.cls = CLS_DOUBLE;
					dec_d.cnt = 3'd2;
				end
			end
		end else if (b_s1 != 0) begin
			if (c_s1 == 0 || ((c_s1 > 0) != (b_s1 > 0))) begin
				dec_d.cls = CLS_TWO;
				dec_d.cnt = 3'd2;
			end
		end else begin
			dec_d.cls = (c_s1 == 0) ? CLS_INF : CLS_NONE;
		end
		dec_d.sq_rad = (d > 0) ? SQD_RAD_W'({d[DR_W-1:0], {(2*FRAC_BITS){1'b0}}}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chn_v_s[0] <= 1'b0;
		end else if (adv) begin
			chn_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chn_s[0] <= dec_d;
		end
	end

	// recurrence stages
	for (genvar i = 1; i <= N_CH; i++) begin : g_ch
		if (i <= SQD_ST) begin : g_sqd
			localparam int BASE = (i - 1) * STEPS;
			// square root of the scaled discriminant, two digits per stage
			always_comb begin
				logic [SQD_REM_W-1:0] trial;
				chn_d[i] = chn_s[i-1];
				for (int k = 0; k < STEPS; k++) begin
					if (BASE + k < SQD_N) begin
						chn_d[i].sq_rem = {chn_d[i].sq_rem[SQD_REM_W-3:0],
							chn_d[i].sq_rad[SQD_RAD_W-1 -: 2]};
						chn_d[i].sq_rad = chn_d[i].sq_rad << 2;
						trial = SQD_REM_W'({chn_d[i].sq_root, 2'b01});
						chn_d[i].sq_root = chn_d[i].sq_root << 1;
						if (chn_d[i].sq_rem >= trial) begin
							chn_d[i].sq_rem     = chn_d[i].sq_rem - trial;
							chn_d[i].sq_root[0] = 1'b1;
						end
					end
				end
			end
		end else if (i == NUM_IDX) begin : g_num
			// numerators and sign-magnitude split for the dividers
			always_comb begin
				logic signed [NUM_W-1:0] bf, s, n0, n1;
				chn_d[i] = chn_s[i-1];
				bf = NUM_W'(chn_s[i-1].b) <<< FRAC_BITS;
				s  = $signed(NUM_W'(chn_s[i-1].sq_root));
				n0 = chn_s[i-1].lin ? -(NUM_W'(chn_s[i-1].c) <<< FRAC_BITS) : s - bf;
				n1 = -bf - s;
				chn_d[i].dv_q[0]   = n0[NUM_W-1] ? MAG_W'(-n0) : MAG_W'(n0);
				chn_d[i].dv_q[1]   = n1[NUM_W-1] ? MAG_W'(-n1) : MAG_W'(n1);
				chn_d[i].dv_neg[0] = n0[NUM_W-1] ^ chn_s[i-1].den[DEN_W-1];
				chn_d[i].dv_neg[1] = n1[NUM_W-1] ^ chn_s[i-1].den[DEN_W-1];
				chn_d[i].dv_den    = chn_s[i-1].den[DEN_W-1] ?
					DEN_W'(-chn_s[i-1].den) : DEN_W'(chn_s[i-1].den);
				chn_d[i].dv_rem    = '0;
			end
		end else if (i < RT_FIRST) begin : g_div
			localparam int BASE = (i - DIV_FIRST) * STEPS;
			// restoring division on magnitudes, both lanes side by side
			always_comb begin
				chn_d[i] = chn_s[i-1];
				for (int l = 0; l < 2; l++) begin
					for (int k = 0; k < STEPS; k++) begin
						if (BASE + k < MAG_W) begin
							chn_d[i].dv_rem[l] = {chn_d[i].dv_rem[l][DREM_W-2:0],
								chn_d[i].dv_q[l][MAG_W-1]};
							chn_d[i].dv_q[l] = chn_d[i].dv_q[l] << 1;
							if (chn_d[i].dv_rem[l] >= DREM_W'(chn_d[i].dv_den)) begin
								chn_d[i].dv_rem[l]  = chn_d[i].dv_rem[l]
									- DREM_W'(chn_d[i].dv_den);
								chn_d[i].dv_q[l][0] = 1'b1;
							end
						end
					end
				end
			end
		end else begin : g_rt
			localparam int BASE = (i - RT_FIRST) * STEPS;
			// square root of the clamped y root, both lanes side by side
			always_comb begin
				logic [RT_REM_W-1:0] trial;
				chn_d[i] = chn_s[i-1];
				for (int l = 0; l < 2; l++) begin
					if (i == RT_FIRST) begin
						chn_d[i].rt_rad[l]  = chn_s[i-1].dv_neg[l] ? '0 :
							RT_RAD_W'({chn_s[i-1].dv_q[l], {FRAC_BITS{1'b0}}});
						chn_d[i].rt_rem[l]  = '0;
						chn_d[i].rt_root[l] = '0;
					end
					for (int k = 0; k < STEPS; k++) begin
						if (BASE + k < RT_N) begin
							chn_d[i].rt_rem[l] = {chn_d[i].rt_rem[l][RT_REM_W-3:0],
								chn_d[i].rt_rad[l][RT_RAD_W-1 -: 2]};
							chn_d[i].rt_rad[l] = chn_d[i].rt_rad[l] << 2;
							trial = RT_REM_W'({chn_d[i].rt_root[l], 2'b01});
							chn_d[i].rt_root[l] = chn_d[i].rt_root[l] << 1;
							if (chn_d[i].rt_rem[l] >= trial) begin
								chn_d[i].rt_rem[l]     = chn_d[i].rt_rem[l] - trial;
								chn_d[i].rt_root[l][0] = 1'b1;
							end
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				chn_v_s[i] <= 1'b0;
			end else if (adv) begin
				chn_v_s[i] <= chn_v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				chn_s[i] <= chn_d[i];
			end
		end
	end

	// output register: place roots by class, unused fields zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chn_v_s[N_CH];
		end
	end

	always_ff @(posedge clk) begin
		logic [OUT_W-1:0] p0, p1, ps;
		p0 = OUT_W'(chn_s[N_CH].rt_root[0]);
		p1 = OUT_W'(chn_s[N_CH].rt_root[1]);
		ps = chn_s[N_CH].sel1 ? p1 : p0;
		if (adv) begin
			cls_q <= chn_s[N_CH].cls;
			cnt_q <= chn_s[N_CH].cnt;
			case (chn_s[N_CH].cls)
				CLS_FOUR: begin
					r1_q <= p0;
					r2_q <= p1;
					r3_q <= OUT_W'(0) - p0;
					r4_q <= OUT_W'(0) - p1;
				end
				CLS_TWO, CLS_DOUBLE: begin
					r1_q <= ps;
					r2_q <= OUT_W'(0) - ps;
					r3_q <= '0;
					r4_q <= '0;
				end
				default: begin
					r1_q <= '0;
					r2_q <= '0;
					r3_q <= '0;
					r4_q <= '0;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign solution_class = cls_q;
	assign root_count     = cnt_q;
	assign root_one       = $signed(r1_q);
	assign root_two       = $signed(r2_q);
	assign root_three     = $signed(r3_q);
	assign root_four      = $signed(r4_q);

endmodule
`default_nettype wire

[rtl/biq_checker.sv]
// biq_checker: port-level assertions on the root solver, bound to its top level
`default_nettype none
module biq_checker import biq_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic signed [COEF_W-1:0] coef_quartic,
	input wire logic signed [COEF_W-1:0] coef_square,
	input wire logic signed [COEF_W-1:0] coef_const,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic [2:0]               solution_class,
	input wire logic [2:0]               root_count,
	input wire logic signed [OUT_W-1:0]  root_one,
	input wire logic signed [OUT_W-1:0]  root_two,
	input wire logic signed [OUT_W-1:0]  root_three,
	input wire logic signed [OUT_W-1:0]  root_four
);

	// input side only backs up while a finished beat is held
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output beat");

	// root count follows the class
	a_cnt_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((solution_class == CLS_FOUR && root_count == 3'd4) ||
			((solution_class == CLS_TWO || solution_class == CLS_DOUBLE) && root_count == 3'd2) ||
			((solution_class == CLS_NONE || solution_class == CLS_INF) && root_count == 3'd0)))
		else $error("root count does not match solution class");

	// paired roots are negatives of each other, unused fields zero
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_count == 3'd2) |->
			(root_two == -root_one && root_three == 0 && root_four == 0))
		else $error("two-root beat malformed");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_count == 3'd0) |->
			(root_one == 0 && root_two == 0 && root_three == 0 && root_four == 0))
		else $error("empty beat carries roots");

	// a held beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(root_one) && $stable(solution_class)))
		else $error("held output beat changed");

endmodule

bind biquadratic_root_solver biq_checker u_biq_checker (.*);
`default_nettype wire
